>>> rtl/bpc_pkg.sv
// bpc_pkg: shared types, constants and reciprocal table for the
// barometric pressure compensation unit
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package bpc_pkg;

    localparam int CHANNELS_DEF = 8;
    localparam int CAL_BYTES    = 18;
    localparam int STAGES       = 10;
    localparam int RECIP_W      = 27;

    localparam logic [0:0] OP_LOAD    = 1'b0;
    localparam logic [0:0] OP_CONVERT = 1'b1;

    typedef enum logic [0:0] {
        REG_TEMP_OS  = 1'b0,
        REG_PRESS_OS = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        logic [0:0]  op;
        logic [2:0]  channel;
        logic [4:0]  coef_index;
        logic [7:0]  coef_byte;
        logic [23:0] raw_press_code;
        logic [23:0] raw_temp_code;
    } t_in_item;

    typedef struct packed {
        logic [2:0]         out_channel;
        logic signed [23:0] temperature_q8;
        logic signed [31:0] pressure_q6;
        logic               saturated;
    } t_out_item;

    // one channel's calibration block, byte i at [i]
    typedef logic [CAL_BYTES-1:0][7:0] t_cal_row;

    // rounded 2^44 / k for the oversampling scale factors
    // k = 524288, 1572864, 3670016, 7864320, 253952, 516096, 1040384, 2088960
    function automatic logic [RECIP_W-1:0] recip(input logic [2:0] sel);
        logic [RECIP_W-1:0] r;
        unique case (sel)
            3'd0:    r = RECIP_W'(33554432);
            3'd1:    r = RECIP_W'(11184811);
            3'd2:    r = RECIP_W'(4793490);
            3'd3:    r = RECIP_W'(2236962);
            3'd4:    r = RECIP_W'(69273666);
            3'd5:    r = RECIP_W'(34087042);
            3'd6:    r = RECIP_W'(16909320);
            default: r = RECIP_W'(8421505);
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/bpc_datapath.sv
// bpc_datapath: ten-stage fixed-point pipeline for scaling and the
// compensation polynomials; stage enables come from the top level
// depends on bpc_pkg
`timescale 1ns / 1ps
`default_nettype none

module bpc_datapath (
    input  wire logic                          i_clk,
    input  wire logic [bpc_pkg::STAGES:1]      i_en,
    input  wire bpc_pkg::t_in_item             i_item,
    input  wire logic [2:0]                    i_temp_os,
    input  wire logic [2:0]                    i_press_os,
    input  wire bpc_pkg::t_cal_row             i_row,
    output bpc_pkg::t_out_item                 o_out
);

    localparam int RW = bpc_pkg::RECIP_W;

    // stage 1: raw codes and reciprocals
    logic [2:0]         r1_ch;
    logic signed [23:0] r1_rawt, r1_rawp;
    logic [RW-1:0]      r1_rt, r1_rp;

    // stage 2: scale products, unpacked coefficients
    logic [2:0]         r2_ch;
    logic signed [51:0] r2_mt, r2_mp;
    logic signed [11:0] r2_c0, r2_c1;
    logic signed [19:0] r2_c00, r2_c10;
    logic signed [15:0] r2_c01, r2_c11, r2_c20, r2_c21, r2_c30;

    // stage 3
    logic [2:0]         r3_ch;
    logic signed [30:0] r3_t24;
    logic signed [22:0] r3_t16, r3_p16;
    logic signed [11:0] r3_c0, r3_c1;
    logic signed [19:0] r3_c00, r3_c10;
    logic signed [15:0] r3_c01, r3_c11, r3_c20, r3_c21, r3_c30;

    // stage 4
    logic [2:0]         r4_ch;
    logic signed [42:0] r4_ta;
    logic signed [38:0] r4_pa, r4_pd;
    logic signed [22:0] r4_t16, r4_p16;
    logic signed [11:0] r4_c0;
    logic signed [19:0] r4_c00, r4_c10;
    logic signed [15:0] r4_c01, r4_c11, r4_c20;

    // stage 5
    logic [2:0]         r5_ch;
    logic signed [23:0] r5_tq;
    logic               r5_sat;
    logic signed [37:0] r5_a, r5_d;
    logic signed [22:0] r5_t16, r5_p16;
    logic signed [19:0] r5_c00, r5_c10;
    logic signed [15:0] r5_c01;

    // stage 6
    logic [2:0]         r6_ch;
    logic signed [23:0] r6_tq;
    logic               r6_sat;
    logic signed [60:0] r6_pb, r6_pe;
    logic signed [22:0] r6_t16, r6_p16;
    logic signed [19:0] r6_c00, r6_c10;
    logic signed [15:0] r6_c01;

    // stage 7
    logic [2:0]         r7_ch;
    logic signed [23:0] r7_tq;
    logic               r7_sat;
    logic signed [42:0] r7_bb, r7_e;
    logic signed [22:0] r7_t16, r7_p16;
    logic signed [19:0] r7_c00;

    // stage 8
    logic [2:0]         r8_ch;
    logic signed [23:0] r8_tq;
    logic               r8_sat;
    logic signed [65:0] r8_pf, r8_pt;
    logic signed [19:0] r8_c00;

    // stage 9
    logic [2:0]         r9_ch;
    logic signed [23:0] r9_tq;
    logic               r9_sat;
    logic signed [48:0] r9_total;

    // stage 10
    bpc_pkg::t_out_item r10_out;

    // combinational helpers
    logic signed [52:0] w_t_sum, w_t_shr, w_p_sum, w_p_shr;
    logic signed [31:0] w_t16_sum, w_t16_shr, w_p16_sum, w_p16_shr;
    logic signed [30:0] w_p24;
    logic signed [43:0] w_ta_sum, w_ta_shr;
    logic signed [28:0] w_tq;
    logic signed [61:0] w_pb_sum, w_pb_shr, w_pe_sum, w_pe_shr;
    logic signed [66:0] w_pf_sum, w_pf_shr, w_pt_sum, w_pt_shr;
    logic signed [49:0] w_pq_sum, w_pq_shr;
    logic signed [38:0] w_pq;

    assign o_out = r10_out;

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r1_ch   <= i_item.channel;
            r1_rawt <= i_item.raw_temp_code;
            r1_rawp <= i_item.raw_press_code;
            r1_rt   <= bpc_pkg::recip(i_temp_os);
            r1_rp   <= bpc_pkg::recip(i_press_os);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r2_ch  <= r1_ch;
            r2_mt  <= r1_rawt * $signed({1'b0, r1_rt});
            r2_mp  <= r1_rawp * $signed({1'b0, r1_rp});
            r2_c0  <= {i_row[0], i_row[1][7:4]};
            r2_c1  <= {i_row[1][3:0], i_row[2]};
            r2_c00 <= {i_row[3], i_row[4], i_row[5][7:4]};
            r2_c10 <= {i_row[5][3:0], i_row[6], i_row[7]};
            r2_c01 <= {i_row[8], i_row[9]};
            r2_c11 <= {i_row[10], i_row[11]};
            r2_c20 <= {i_row[12], i_row[13]};
            r2_c21 <= {i_row[14], i_row[15]};
            r2_c30 <= {i_row[16], i_row[17]};
        end
    end

    // q7.24 scaled values, then rounded q16 operands
    always_comb begin
        w_t_sum   = 53'(r2_mt) + 53'(524288);
        w_t_shr   = w_t_sum >>> 20;
        w_p_sum   = 53'(r2_mp) + 53'(524288);
        w_p_shr   = w_p_sum >>> 20;
        w_p24     = w_p_shr[30:0];
        w_t16_sum = 32'($signed(w_t_shr[30:0])) + 32'sd128;
        w_t16_shr = w_t16_sum >>> 8;
        w_p16_sum = 32'(w_p24) + 32'sd128;
        w_p16_shr = w_p16_sum >>> 8;
    end

    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r3_ch  <= r2_ch;
            r3_t24 <= w_t_shr[30:0];
            r3_t16 <= w_t16_shr[22:0];
            r3_p16 <= w_p16_shr[22:0];
            r3_c0  <= r2_c0;
            r3_c1  <= r2_c1;
            r3_c00 <= r2_c00;
            r3_c10 <= r2_c10;
            r3_c01 <= r2_c01;
            r3_c11 <= r2_c11;
            r3_c20 <= r2_c20;
            r3_c21 <= r2_c21;
            r3_c30 <= r2_c30;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[4]) begin
            r4_ch  <= r3_ch;
            r4_ta  <= r3_t24 * r3_c1;
            r4_pa  <= r3_p16 * r3_c30;
            r4_pd  <= r3_p16 * r3_c21;
            r4_t16 <= r3_t16;
            r4_p16 <= r3_p16;
            r4_c0  <= r3_c0;
            r4_c00 <= r3_c00;
            r4_c10 <= r3_c10;
            r4_c01 <= r3_c01;
            r4_c11 <= r3_c11;
            r4_c20 <= r3_c20;
        end
    end

    // temperature: c0*128 + rnd(t24*c1, 16)
    always_comb begin
        w_ta_sum = 44'(r4_ta) + 44'sd32768;
        w_ta_shr = w_ta_sum >>> 16;
        w_tq     = (29'(r4_c0) <<< 7) + 29'($signed(w_ta_shr[27:0]));
    end

    always_ff @(posedge i_clk) begin
        if (i_en[5]) begin
            r5_ch <= r4_ch;
            if (w_tq > 29'sd8388607) begin
                r5_tq  <= 24'sh7FFFFF;
                r5_sat <= 1'b1;
            end else if (w_tq < -29'sd8388608) begin
                r5_tq  <= 24'sh800000;
                r5_sat <= 1'b1;
            end else begin
                r5_tq  <= w_tq[23:0];
                r5_sat <= 1'b0;
            end
            r5_a   <= (38'(r4_c20) <<< 16) + 38'(r4_pa);
            r5_d   <= (38'(r4_c11) <<< 16) + 38'(r4_pd);
            r5_t16 <= r4_t16;
            r5_p16 <= r4_p16;
            r5_c00 <= r4_c00;
            r5_c10 <= r4_c10;
            r5_c01 <= r4_c01;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[6]) begin
            r6_ch  <= r5_ch;
            r6_tq  <= r5_tq;
            r6_sat <= r5_sat;
            r6_pb  <= r5_p16 * r5_a;
            r6_pe  <= r5_p16 * r5_d;
            r6_t16 <= r5_t16;
            r6_p16 <= r5_p16;
            r6_c00 <= r5_c00;
            r6_c10 <= r5_c10;
            r6_c01 <= r5_c01;
        end
    end

    always_comb begin
        w_pb_sum = 62'(r6_pb) + 62'sd32768;
        w_pb_shr = w_pb_sum >>> 16;
        w_pe_sum = 62'(r6_pe) + 62'sd32768;
        w_pe_shr = w_pe_sum >>> 16;
    end

    always_ff @(posedge i_clk) begin
        if (i_en[7]) begin
            r7_ch  <= r6_ch;
            r7_tq  <= r6_tq;
            r7_sat <= r6_sat;
            r7_bb  <= (43'(r6_c10) <<< 16) + w_pb_shr[42:0];
            r7_e   <= (43'(r6_c01) <<< 16) + w_pe_shr[42:0];
            r7_t16 <= r6_t16;
            r7_p16 <= r6_p16;
            r7_c00 <= r6_c00;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[8]) begin
            r8_ch  <= r7_ch;
            r8_tq  <= r7_tq;
            r8_sat <= r7_sat;
            r8_pf  <= r7_p16 * r7_bb;
            r8_pt  <= r7_t16 * r7_e;
            r8_c00 <= r7_c00;
        end
    end

    always_comb begin
        w_pf_sum = 67'(r8_pf) + 67'sd32768;
        w_pf_shr = w_pf_sum >>> 16;
        w_pt_sum = 67'(r8_pt) + 67'sd32768;
        w_pt_shr = w_pt_sum >>> 16;
    end

    always_ff @(posedge i_clk) begin
        if (i_en[9]) begin
            r9_ch    <= r8_ch;
            r9_tq    <= r8_tq;
            r9_sat   <= r8_sat;
            r9_total <= (49'(r8_c00) <<< 16) + w_pf_shr[48:0] + w_pt_shr[48:0];
        end
    end

    always_comb begin
        w_pq_sum = 50'(r9_total) + 50'sd512;
        w_pq_shr = w_pq_sum >>> 10;
        w_pq     = w_pq_shr[38:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en[10]) begin
            r10_out.out_channel    <= r9_ch;
            r10_out.temperature_q8 <= r9_tq;
            if (w_pq > 39'sd2147483647) begin
                r10_out.pressure_q6 <= 32'sh7FFFFFFF;
                r10_out.saturated   <= 1'b1;
            end else if (w_pq < -39'sd2147483648) begin
                r10_out.pressure_q6 <= 32'sh80000000;
                r10_out.saturated   <= 1'b1;
            end else begin
                r10_out.pressure_q6 <= w_pq[31:0];
                r10_out.saturated   <= r9_sat;
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/barometric_pressure_compensation_unit.sv
// barometric_pressure_compensation_unit: top level with handshake, config
// registers, calibration memory and pipeline valid chain
// depends on bpc_pkg and bpc_datapath
`timescale 1ns / 1ps
`default_nettype none

// channel  direction  signals                          payload
// input    in         i_valid / o_ready                i_in  (t_in_item)
// output   out        o_valid / i_ready                o_out (t_out_item)
// config   in         i_cfg_valid / o_cfg_ready        i_cfg_index, i_cfg_data
//
// one item per cycle while no output stall holds the pipeline; a measurement item
// accepted at an edge fills stage one and moves through the register stages in order
// to the last one, where o_valid goes up and the result can leave when i_ready is high
// load items and measurements on a channel beyond CHANNELS give no result
// reset clears the valid bits and the oversampling registers; calibration
// bytes are not cleared and hold garbage until loaded
// a stall on the output only holds stages that are occupied, bubbles fill up

module barometric_pressure_compensation_unit #(
    parameter int CHANNELS = bpc_pkg::CHANNELS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire bpc_pkg::t_in_item i_in,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output bpc_pkg::t_out_item     o_out,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire bpc_pkg::t_cfg_reg i_cfg_index,
    input  wire logic [2:0]        i_cfg_data
);

    localparam int NS   = bpc_pkg::STAGES;
    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // calibration memory, one row of 18 bytes per channel
    bpc_pkg::t_cal_row r_cal [CHANNELS];
    bpc_pkg::t_cal_row r_row;

    logic [2:0]     r_temp_os, r_press_os;
    logic [NS:1]    r_vld;
    logic [NS:1]    w_en;
    logic [CH_W-1:0] w_ch_idx;
    logic           w_ch_ok, w_acc, w_meas, w_load;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = w_en[1];
    assign o_valid     = r_vld[NS];

    assign w_ch_idx = CH_W'(i_in.channel);
    assign w_ch_ok  = int'(i_in.channel) < CHANNELS;
    assign w_acc    = i_valid && w_en[1];
    assign w_meas   = w_acc && w_ch_ok && (i_in.op == bpc_pkg::OP_CONVERT);
    assign w_load   = w_acc && w_ch_ok && (i_in.op == bpc_pkg::OP_LOAD)
                      && (int'(i_in.coef_index) < bpc_pkg::CAL_BYTES);

    // a stage advances when it is empty or the next one advances
    always_comb begin
        w_en[NS] = !r_vld[NS] || i_ready;
        for (int k = NS - 1; k >= 1; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld      <= '0;
            r_temp_os  <= '0;
            r_press_os <= '0;
        end else begin
            if (w_en[1]) begin
                r_vld[1] <= w_meas;
            end
            for (int k = 2; k <= NS; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    bpc_pkg::REG_TEMP_OS:  r_temp_os  <= i_cfg_data;
                    bpc_pkg::REG_PRESS_OS: r_press_os <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // byte write on load, registered row read on measurement
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_cal[w_ch_idx][i_in.coef_index] <= i_in.coef_byte;
        end
        if (w_meas) begin
            r_row <= r_cal[w_ch_idx];
        end
    end

    bpc_datapath u_datapath (
        .i_clk      (i_clk),
        .i_en       (w_en),
        .i_item     (i_in),
        .i_temp_os  (r_temp_os),
        .i_press_os (r_press_os),
        .i_row      (r_row),
        .o_out      (o_out)
    );

endmodule

`default_nettype wire
